[rtl/pcx_rle_palette_decoder_core_defines.svh]
// Assertion macros shared by the PCX run-length decoder RTL.
`ifndef PCX_RLE_PALETTE_DECODER_CORE_DEFINES_SVH
`define PCX_RLE_PALETTE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcx_rle_pkg.sv]
// Shared types and constants of the PCX run-length palette decoder.
`timescale 1ns / 1ps
package pcx_rle_pkg;

  localparam int unsigned DimBitsDefault = 16;
  localparam int unsigned CfgBits        = 17;
  localparam int unsigned CoordBits      = 16;
  localparam int unsigned ColorBits      = 24;
  localparam int unsigned IdxBits        = 8;
  localparam int unsigned CountBits      = 6;
  localparam int unsigned PalDepth       = 256;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned InDataBits     = 40;
  localparam int unsigned OutDataBits    = 56;

  localparam logic [CfgBits-1:0] WidthReset  = 17'd320;
  localparam logic [CfgBits-1:0] HeightReset = 17'd200;

  localparam logic [IdxBits-1:0] RunMark = 8'hC0;
  localparam logic [IdxBits-1:0] RunMask = 8'h3F;

  localparam logic KindPal  = 1'b0;
  localparam logic KindData = 1'b1;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic {
    CMD_PAL,
    CMD_PIX
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [IdxBits-1:0]     index;
    logic [ColorBits-1:0]   color;
    logic [CountBits-1:0]   count;
  } cmd_t;

endpackage

[rtl/pcx_rle_palette_decoder_core.sv]
// Top level of the PCX 8-bit run-length decoder with RGB palette lookup.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata, tuser = kind
//  m_axis    out  tvalid/tready              tdata, tlast = last_of_run, tuser = image_complete
//  cfg       in   cfg_wr_en_i (no ready)     cfg_addr_i, cfg_wdata_i
//
// Palette writes and run markers each occupy a single input beat.
// A literal byte is handled in the back end as a palette read, then an emit;
// a run reads the palette once, then emits one pixel per cycle while the output register is free, ending at a row end.
// A four-entry command queue lets input continue while a run drains.
// Reset clears control state only; the palette is not cleared.
`timescale 1ns / 1ps
module pcx_rle_palette_decoder_core #(
  parameter int unsigned DIM_BITS = pcx_rle_pkg::DimBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_wr_en_i,
  input  logic                                  cfg_addr_i,
  input  logic [pcx_rle_pkg::CfgBits-1:0]       cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // palette_index, palette_color, data_byte
  input  logic [pcx_rle_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // kind
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // pixel_color, pixel_column, pixel_row
  output logic [pcx_rle_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  // image_complete
  output logic                                  m_axis_tuser_o
);
  import pcx_rle_pkg::*;

  localparam logic [CfgBits-1:0] DimMax = CfgBits'(1) << DIM_BITS;

  logic [CfgBits-1:0]  width_q, height_q;
  logic [DIM_BITS:0]   width_eff, height_eff;
  logic                push, pop, full, empty;
  cmd_t                cmd_in, cmd_head;
  logic [ColorBits-1:0] px_color;
  logic [CoordBits-1:0] px_col, px_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr_en_i) begin
      if (cfg_addr_i == CfgWidth) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == CfgHeight) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      width_eff = (DIM_BITS+1)'(1);
    end else if (width_q > DimMax) begin
      width_eff = (DIM_BITS+1)'(DimMax);
    end else begin
      width_eff = (DIM_BITS+1)'(width_q);
    end
    if (height_q == '0) begin
      height_eff = (DIM_BITS+1)'(1);
    end else if (height_q > DimMax) begin
      height_eff = (DIM_BITS+1)'(DimMax);
    end else begin
      height_eff = (DIM_BITS+1)'(height_q);
    end
  end

  pcx_rle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .pal_index_i (s_axis_tdata_i[7:0]),
    .pal_color_i (s_axis_tdata_i[31:8]),
    .data_byte_i (s_axis_tdata_i[39:32]),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  pcx_rle_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (cmd_head)
  );

  pcx_rle_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_head),
    .empty_i          (empty),
    .pop_o            (pop),
    .width_i          (width_eff),
    .height_i         (height_eff),
    .m_valid_o        (m_axis_tvalid_o),
    .m_ready_i        (m_axis_tready_i),
    .pixel_color_o    (px_color),
    .pixel_column_o   (px_col),
    .pixel_row_o      (px_row),
    .last_of_run_o    (m_axis_tlast_o),
    .image_complete_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {px_row, px_col, px_color};

endmodule

[rtl/pcx_rle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcx_rle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pcx_rle_front.sv]
// Input side: accepts beats, tracks run markers and issues decode commands.
`timescale 1ns / 1ps
module pcx_rle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic                kind_i,
  input  logic [7:0]          pal_index_i,
  input  logic [23:0]         pal_color_i,
  input  logic [7:0]          data_byte_i,
  input  logic                full_i,
  output logic                push_o,
  output pcx_rle_pkg::cmd_t   cmd_o
);
  import pcx_rle_pkg::*;

  logic                 accept;
  logic                 is_mark;
  logic                 awaiting_q, awaiting_d;
  logic [CountBits-1:0] pending_q, pending_d;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && !full_i;
  assign is_mark   = (data_byte_i & RunMark) == RunMark;

  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_PIX;
    cmd_o.index = data_byte_i;
    cmd_o.color = pal_color_i;
    cmd_o.count = CountBits'(1);
    awaiting_d  = awaiting_q;
    pending_d   = pending_q;
    if (accept) begin
      if (kind_i == KindPal) begin
        push_o      = 1'b1;
        cmd_o.kind  = CMD_PAL;
        cmd_o.index = pal_index_i;
      end else if (awaiting_q) begin
        // zero-length run consumes the index byte silently
        push_o      = (pending_q != '0);
        cmd_o.count = pending_q;
        awaiting_d  = 1'b0;
        pending_d   = '0;
      end else if (is_mark) begin
        awaiting_d  = 1'b1;
        pending_d   = CountBits'(data_byte_i & RunMask);
      end else begin
        push_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pending_q  <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pending_q  <= pending_d;
    end
  end

endmodule

[rtl/pcx_rle_queue.sv]
// Short command FIFO between the front and back ends.
`timescale 1ns / 1ps
module pcx_rle_queue #(
  parameter int unsigned DEPTH = pcx_rle_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcx_rle_pkg::cmd_t  cmd_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output pcx_rle_pkg::cmd_t  head_o
);
  import pcx_rle_pkg::*;
  `include "pcx_rle_palette_decoder_core_defines.svh"

  localparam int unsigned PtrBits = $clog2(DEPTH);
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  cmd_t               entry_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d;
  logic [PtrBits-1:0] rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrBits'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `PCX_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `PCX_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `PCX_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push_i && !pop_i, !empty_o, "push lost")

endmodule

[rtl/pcx_rle_back.sv]
// Output side: palette store, pixel sequencing, coordinates and output register.
`timescale 1ns / 1ps
module pcx_rle_back #(
  parameter int unsigned DIM_BITS = pcx_rle_pkg::DimBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcx_rle_pkg::cmd_t   cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic [DIM_BITS:0]   width_i,
  input  logic [DIM_BITS:0]   height_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [23:0]         pixel_color_o,
  output logic [15:0]         pixel_column_o,
  output logic [15:0]         pixel_row_o,
  output logic                last_of_run_o,
  output logic                image_complete_o
);
  import pcx_rle_pkg::*;
  `include "pcx_rle_palette_decoder_core_defines.svh"

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic                 state_q, state_d;
  logic [CountBits-1:0] remaining_q, remaining_d;
  logic [DIM_BITS-1:0]  col_q, col_d;
  logic [DIM_BITS-1:0]  row_q, row_d;
  logic                 frame_done_q, frame_done_d;
  logic                 out_valid_q, out_valid_d;
  logic [ColorBits-1:0] out_color_q;
  logic [CoordBits-1:0] out_col_q, out_row_q;
  logic                 out_last_q, out_done_q;

  logic                 ram_we, ram_re, start, load, slot_free;
  logic [ColorBits-1:0] ram_rdata;
  logic [DIM_BITS:0]    col_inc, row_inc;
  logic                 row_end, done, last_px;

  pcx_rle_ram #(
    .WIDTH (ColorBits),
    .DEPTH (PalDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.index),
    .wdata_i (cmd_i.color),
    .re_i    (ram_re),
    .raddr_i (cmd_i.index),
    .rdata_o (ram_rdata)
  );

  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign ram_we    = pop_o && (cmd_i.kind == CMD_PAL);
  assign ram_re    = pop_o && (cmd_i.kind == CMD_PIX);
  assign start     = ram_re && !frame_done_q && (cmd_i.count != '0);
  assign slot_free = !out_valid_q || m_ready_i;
  assign load      = (state_q == StEmit) && slot_free;

  assign col_inc = {1'b0, col_q} + (DIM_BITS+1)'(1);
  assign row_inc = {1'b0, row_q} + (DIM_BITS+1)'(1);
  assign row_end = col_inc >= width_i;
  assign done    = row_end && (row_inc >= height_i);
  assign last_px = (remaining_q == CountBits'(1)) || row_end;

  always_comb begin
    state_d      = state_q;
    remaining_d  = remaining_q;
    col_d        = col_q;
    row_d        = row_q;
    frame_done_d = frame_done_q;
    out_valid_d  = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (start) begin
      state_d     = StEmit;
      remaining_d = cmd_i.count;
    end
    if (load) begin
      out_valid_d = 1'b1;
      remaining_d = remaining_q - CountBits'(1);
      if (done) begin
        frame_done_d = 1'b1;
        col_d        = '0;
        row_d        = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_inc[DIM_BITS-1:0];
      end else begin
        col_d = col_inc[DIM_BITS-1:0];
      end
      if (last_px) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      remaining_q  <= '0;
      col_q        <= '0;
      row_q        <= '0;
      frame_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      remaining_q  <= remaining_d;
      col_q        <= col_d;
      row_q        <= row_d;
      frame_done_q <= frame_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_color_q <= ram_rdata;
      out_col_q   <= CoordBits'(col_q);
      out_row_q   <= CoordBits'(row_q);
      out_last_q  <= last_px;
      out_done_q  <= done;
    end
  end

  assign m_valid_o        = out_valid_q;
  assign pixel_color_o    = out_color_q;
  assign pixel_column_o   = out_col_q;
  assign pixel_row_o      = out_row_q;
  assign last_of_run_o    = out_last_q;
  assign image_complete_o = out_done_q;

  `PCX_ASSERT_IMPL(a_quiet_after_done, clk_i, rst_ni, frame_done_q, !load, "pixel after frame")
  `PCX_ASSERT_IMPL(a_done_ends_run, clk_i, rst_ni, load && done, last_px, "frame end not last")
  `PCX_ASSERT_IMPL(a_emit_count, clk_i, rst_ni, state_q == StEmit, remaining_q != '0,
                   "emitting with empty count")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the PCX run-length palette decoder core.
`timescale 1ns / 1ps
module tb_top;
  import pcx_rle_pkg::*;

  typedef struct {
    logic                 kind;
    logic [IdxBits-1:0]   index;
    logic [ColorBits-1:0] color;
    logic [7:0]           data;
  } stream_item_t;

  typedef struct packed {
    logic [ColorBits-1:0] color;
    logic [CoordBits-1:0] col;
    logic [CoordBits-1:0] row;
    logic                 last;
    logic                 done;
  } pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_wr_en_i = 1'b0;
  logic                   cfg_addr_i = CfgWidth;
  logic [CfgBits-1:0]     cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [InDataBits-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = KindPal;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;
  logic                   m_axis_tuser_o;

  pcx_rle_palette_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  stream_item_t bytes_pending[$];
  pixel_t       pixels_due[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;

  // decoder mirror
  logic [ColorBits-1:0] pal_rgb[PalDepth];
  logic [CfgBits-1:0]   width_cfg = WidthReset;
  logic [CfgBits-1:0]   height_cfg = HeightReset;
  bit                   run_wait = 1'b0;
  int unsigned          run_len = 0;
  int unsigned          cur_col = 0;
  int unsigned          cur_row = 0;
  bit                   img_done = 1'b0;

  // stimulus-side palette bookkeeping
  bit                   pal_written[PalDepth];
  bit                   gen_await = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned dim_limit(input logic [CfgBits-1:0] v);
    if (v == 0) return 1;
    if (v > 17'h10000) return 32'h10000;
    return 32'(v);
  endfunction

  task automatic emit_pixels(input logic [7:0] idx, input int unsigned cnt);
    pixel_t      held;
    bit          have_held;
    bit          row_end;
    int unsigned w;
    int unsigned h;
    w = dim_limit(width_cfg);
    h = dim_limit(height_cfg);
    have_held = 1'b0;
    held = '0;
    for (int unsigned n = 0; n < cnt && !img_done; n++) begin
      row_end = (cur_col + 1) >= w;
      if (have_held) pixels_due.push_back(held);
      held.color = pal_rgb[idx];
      held.col   = 16'(cur_col);
      held.row   = 16'(cur_row);
      held.last  = 1'b0;
      held.done  = row_end && ((cur_row + 1) >= h);
      have_held  = 1'b1;
      if (held.done) begin
        img_done = 1'b1;
        cur_col  = 0;
        cur_row  = 0;
        break;
      end
      if (row_end) begin
        cur_col = 0;
        cur_row = (cur_row + 1) & 32'hFFFF;
        break;
      end
      cur_col = (cur_col + 1) & 32'hFFFF;
    end
    if (have_held) begin
      held.last = 1'b1;
      pixels_due.push_back(held);
    end
  endtask

  task automatic decode_item(input stream_item_t it);
    if (it.kind == KindPal) begin
      pal_rgb[it.index] = it.color;
    end else if (!img_done) begin
      if (run_wait) begin
        run_wait = 1'b0;
        emit_pixels(it.data, run_len);
        run_len = 0;
      end else if ((it.data & RunMark) == RunMark) begin
        run_wait = 1'b1;
        run_len  = 32'(it.data & RunMask);
      end else begin
        emit_pixels(it.data, 1);
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    bit fire;
    if (rst_ni) begin
      fire = !s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_item(bytes_pending.pop_front());
        fire = 1'b1;
      end
      if (fire) begin
        if (bytes_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= bytes_pending[0].kind;
          s_axis_tdata_i  <= {bytes_pending[0].data, bytes_pending[0].color,
                              bytes_pending[0].index};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.color = m_axis_tdata_o[23:0];
        got.col   = m_axis_tdata_o[39:24];
        got.row   = m_axis_tdata_o[55:40];
        got.last  = m_axis_tlast_o;
        got.done  = m_axis_tuser_o;
        if (pixels_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected beat: color %h col %0d row %0d last %b done %b",
                   $time, got.color, got.col, got.row, got.last, got.done);
        end else begin
          want = pixels_due.pop_front();
          if (got.color != want.color || got.col != want.col || got.row != want.row ||
              got.last != want.last || got.done != want.done) begin
            mismatch_cnt++;
            $display("%0t mismatch: expected color %h col %0d row %0d last %b done %b",
                     $time, want.color, want.col, want.row, want.last, want.done);
            $display("%0t            actual color %h col %0d row %0d last %b done %b",
                     $time, got.color, got.col, got.row, got.last, got.done);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_pal(input logic [7:0] idx, input logic [23:0] rgb);
    stream_item_t it;
    it.kind  = KindPal;
    it.index = idx;
    it.color = rgb;
    it.data  = 8'($urandom_range(255));
    pal_written[idx] = 1'b1;
    bytes_pending.push_back(it);
  endtask

  task automatic push_data(input logic [7:0] b);
    stream_item_t it;
    it.kind  = KindData;
    it.index = 8'($urandom_range(255));
    it.color = 24'($urandom);
    it.data  = b;
    bytes_pending.push_back(it);
  endtask

  function automatic logic [7:0] pick_written(input bit literal_only);
    int unsigned r;
    do begin
      r = literal_only ? $urandom_range(8'hBF) : $urandom_range(8'hFF);
    end while (!pal_written[r]);
    return 8'(r);
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned r;
    int unsigned cnt;
    @(negedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        push_pal(8'($urandom_range(255)), 24'($urandom));
      end else if (gen_await) begin
        push_data(pick_written(1'b0));
        gen_await = 1'b0;
      end else if ($urandom_range(99) < 45) begin
        r = $urandom_range(99);
        if (r < 10) cnt = 0;
        else if (r < 70) cnt = $urandom_range(6, 1);
        else if (r < 90) cnt = $urandom_range(30, 7);
        else cnt = $urandom_range(63, 31);
        push_data(RunMark | 8'(cnt));
        gen_await = 1'b1;
      end else begin
        push_data(pick_written(1'b1));
      end
    end
    if (gen_await) begin
      push_data(pick_written(1'b0));
      gen_await = 1'b0;
    end
  endtask

  task automatic drain_pipeline();
    do @(negedge clk_i);
    while (bytes_pending.size() > 0 || s_axis_tvalid_i || pixels_due.size() > 0);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic addr, input logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    if (addr == CfgWidth) width_cfg = val;
    else height_cfg = val;
  endtask

  task automatic set_dims(input logic [CfgBits-1:0] w, input logic [CfgBits-1:0] h);
    cfg_write(CfgWidth, w);
    cfg_write(CfgHeight, h);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 17;
    rx_idle_pct = 59;

    set_dims(17'd5, 17'h1FFFF);
    @(negedge clk_i);
    push_pal(8'h00, 24'h000000);
    push_pal(8'hFF, 24'hFFFFFF);
    push_pal(8'hBF, 24'h123456);
    push_pal(8'h40, 24'hA5A5A5);
    push_pal(8'h3F, 24'h5A5A5A);
    push_pal(8'h80, 24'h0F1E2D);
    push_data(8'h00);
    push_data(8'hBF);
    push_data(8'hC3);
    push_data(8'hFF);
    // zero-length run
    push_data(8'hC0);
    push_data(8'h00);
    // run past row end
    push_data(8'hFF);
    push_data(8'h40);
    // palette update while the run index is pending
    push_data(8'hC2);
    push_pal(8'h3F, 24'h00FF00);
    push_data(8'h3F);
    push_data(8'h80);
    push_data(8'h3F);
    push_data(8'hC1);
    push_data(8'hBF);
    push_pal(8'h00, 24'h800001);
    drain_pipeline();

    set_dims(17'd0, 17'h10000);
    random_phase(45);
    drain_pipeline();

    tx_idle_pct = 59;
    rx_idle_pct = 17;
    set_dims(17'h1FFFF, 17'd1000);
    random_phase(45);
    drain_pipeline();

    set_dims(17'd1, 17'd65535);
    random_phase(45);
    drain_pipeline();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_dims(17'd12, 17'h10000);
    random_phase(45);
    drain_pipeline();

    // finish the image, then bytes that must be ignored
    set_dims(17'd3, 17'd0);
    @(negedge clk_i);
    push_data(8'hCA);
    push_data(8'hFF);
    push_data(8'h00);
    push_pal(8'h10, 24'h00FFFF);
    push_data(8'hC5);
    push_data(8'hBF);
    push_data(8'h3F);
    drain_pipeline();

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[pcx_rle_palette_decoder_core.f]
+incdir+rtl
rtl/pcx_rle_pkg.sv
rtl/pcx_rle_ram.sv
rtl/pcx_rle_front.sv
rtl/pcx_rle_queue.sv
rtl/pcx_rle_back.sv
rtl/pcx_rle_palette_decoder_core.sv
verif/tb_top.sv
